### sv/tcce_pkg.sv
package tcce_pkg;

   localparam int COLUMN_W = 7;
   localparam int ROW_W = 5;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int INDEX_W = 11;
   localparam int KIND_W = 2;
   localparam int COUNT_W = 4;
   localparam int RSP_DATA_W = 40;

   localparam logic [KIND_W-1:0] KIND_CELL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

   localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'd7;
   localparam logic [COUNT_W-1:0] MAX_TAB_SPACES = 4'd8;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0] row;
   } cursor_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_ADVANCE,
      CUR_BACK,
      CUR_NEWLINE,
      CUR_BOTTOM
   } cur_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CELL,
      ST_SCROLL,
      ST_CURSOR
   } state_type;

endpackage

### sv/tcce_cursor_unit.sv
module tcce_cursor_unit
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25,
   parameter int TAB_WIDTH = 8,
   localparam int PHASE_W = $clog2(TAB_WIDTH)
) (
   input  cursor_type         cur,
   input  logic [PHASE_W-1:0] phase,
   input  cur_op_type         op,
   output cursor_type         cur_next,
   output logic [PHASE_W-1:0] phase_next,
   output logic               scroll
);

   localparam logic [COLUMN_W-1:0] LAST_COLUMN = COLUMN_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [PHASE_W-1:0] LAST_TAB_PHASE = PHASE_W'(TAB_WIDTH - 1);
   localparam logic [PHASE_W-1:0] LAST_COLUMN_PHASE = PHASE_W'((COLUMNS - 1) % TAB_WIDTH);

   always_comb begin
      cur_next = cur;
      phase_next = phase;
      scroll = 1'b0;
      unique case (op)
         CUR_HOLD: begin
         end
         CUR_ADVANCE: begin
            if (cur.column == LAST_COLUMN) begin
               // wrap to the next line, scroll on the bottom row
               cur_next.column = '0;
               phase_next = '0;
               if (cur.row == LAST_ROW) begin
                  scroll = 1'b1;
               end else begin
                  cur_next.row = cur.row + 1'b1;
               end
            end else begin
               cur_next.column = cur.column + 1'b1;
               phase_next = (phase == LAST_TAB_PHASE) ? '0 : phase + 1'b1;
            end
         end
         CUR_BACK: begin
            if (cur.column != '0) begin
               cur_next.column = cur.column - 1'b1;
               phase_next = (phase == '0) ? LAST_TAB_PHASE : phase - 1'b1;
            end else if (cur.row != '0) begin
               cur_next.column = LAST_COLUMN;
               cur_next.row = cur.row - 1'b1;
               phase_next = LAST_COLUMN_PHASE;
            end
         end
         CUR_NEWLINE: begin
            cur_next.column = '0;
            phase_next = '0;
            if (cur.row == LAST_ROW) begin
               scroll = 1'b1;
            end else begin
               cur_next.row = cur.row + 1'b1;
            end
         end
         CUR_BOTTOM: begin
            cur_next.column = '0;
            cur_next.row = LAST_ROW;
            phase_next = '0;
         end
         default: begin
         end
      endcase
   end

endmodule

### sv/text_console_cursor_engine.sv
// Cursor engine for a COLUMNS x ROWS text console.
// Input channel req_*: one character byte per transfer. Backspace, tab and
// newline are control codes; every other byte is printed at the cursor.
// Result channel rsp_*: cell writes, scroll-up items and one cursor-position
// item per character, which always closes the run with rsp_tlast high.
// Configuration channel csr_*: the text color attribute, always ready.
// The character is taken in the idle state; the cell, scroll or cursor state
// then registers the first result, and results leave at one per cycle while
// the receiver keeps rsp_tready high. The sequencer drives the shared cursor
// unit on taking a backspace or newline and for cell and scroll results, and
// the block holds req_tready low until the cursor item has been loaded.
// A stalled receiver freezes the sequencer; the pending result holds in the
// output register and nothing is dropped.
// Reset puts the cursor home at (0,0) and the color back to 7; no results
// are pending afterwards.
module text_console_cursor_engine
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ATTR_W-1:0]     csr_data,     // text_color
   // character input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_W-1:0]     req_tdata,    // [7:0] character
   // result output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [6:0] column, [11:7] row, [19:12] glyph, [27:20] attribute,
   // [38:28] cursor_index, [39] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,    // [1:0] kind
   output logic                  rsp_tlast
);

   localparam int PHASE_W = $clog2(TAB_WIDTH);
   localparam int FULL_INDEX_W = INDEX_W + 1;

   // control state
   state_type state_ff, state_in;
   cursor_type cursor_ff, cursor_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ATTR_W-1:0] color_ff, color_in;
   logic rsp_valid_ff, rsp_valid_in;

   // per-character work registers
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CHAR_W-1:0] glyph_ff, glyph_in;
   logic advance_ff, advance_in;

   // output register payload
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic rsp_last_ff, rsp_last_in;

   // shared cursor unit
   cur_op_type unit_op;
   cursor_type unit_cursor;
   logic [PHASE_W-1:0] unit_phase;
   logic unit_scroll;

   logic slot_free;
   logic rsp_load;
   logic [ROW_W:0] tab_gap;
   logic [FULL_INDEX_W-1:0] index_full;

   tcce_cursor_unit #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS),
      .TAB_WIDTH(TAB_WIDTH)
   ) u_cursor (
      .cur(cursor_ff),
      .phase(phase_ff),
      .op(unit_op),
      .cur_next(unit_cursor),
      .phase_next(unit_phase),
      .scroll(unit_scroll)
   );

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);

   // the output register takes a new result when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // spaces up to the next tab stop, capped below
   assign tab_gap = (ROW_W + 1)'(TAB_WIDTH) - (ROW_W + 1)'(phase_ff);

   // row * COLUMNS + column, kept to the low index bits
   assign index_full = FULL_INDEX_W'(cursor_ff.row) * FULL_INDEX_W'(COLUMNS)
                     + FULL_INDEX_W'(cursor_ff.column);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cursor_ff <= '0;
         phase_ff <= '0;
         color_ff <= TEXT_COLOR_RESET;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         advance_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cursor_ff <= cursor_in;
         phase_ff <= phase_in;
         color_ff <= color_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
         advance_ff <= advance_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in = state_ff;
      cursor_in = cursor_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      glyph_in = glyph_ff;
      advance_in = advance_ff;
      unit_op = CUR_HOLD;
      rsp_load = 1'b0;
      rsp_data_in = rsp_data_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_last_in = rsp_last_ff;

      // take a color write at any time; the host is to write only while idle, and the block does not enforce this
      color_in = (csr_valid && csr_ready) ? csr_data : color_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               priority if (req_tdata == CHAR_BACKSPACE) begin
                  // step back now, then blank the cell under the cursor
                  unit_op = CUR_BACK;
                  cursor_in = unit_cursor;
                  phase_in = unit_phase;
                  count_in = COUNT_W'(1);
                  glyph_in = CHAR_BLANK;
                  advance_in = 1'b0;
                  state_in = ST_CELL;
               end else if (req_tdata == CHAR_NEWLINE) begin
                  unit_op = CUR_NEWLINE;
                  cursor_in = unit_cursor;
                  phase_in = unit_phase;
                  count_in = '0;
                  state_in = unit_scroll ? ST_SCROLL : ST_CURSOR;
               end else if (req_tdata == CHAR_TAB) begin
                  count_in = (tab_gap > (ROW_W + 1)'(MAX_TAB_SPACES)) ?
                             MAX_TAB_SPACES : COUNT_W'(tab_gap);
                  glyph_in = CHAR_BLANK;
                  advance_in = 1'b1;
                  state_in = ST_CELL;
               end else begin
                  count_in = COUNT_W'(1);
                  glyph_in = req_tdata;
                  advance_in = 1'b1;
                  state_in = ST_CELL;
               end
            end
         end
         ST_CELL: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_kind_in = KIND_CELL;
               rsp_last_in = 1'b0;
               rsp_data_in = {1'b0, INDEX_W'(0), color_ff, glyph_ff,
                              cursor_ff.row, cursor_ff.column};
               unit_op = advance_ff ? CUR_ADVANCE : CUR_HOLD;
               cursor_in = unit_cursor;
               phase_in = unit_phase;
               count_in = count_ff - 1'b1;
               priority if (unit_scroll) begin
                  state_in = ST_SCROLL;
               end else if (count_ff > COUNT_W'(1)) begin
                  state_in = ST_CELL;
               end else begin
                  state_in = ST_CURSOR;
               end
            end
         end
         ST_SCROLL: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_kind_in = KIND_SCROLL;
               rsp_last_in = 1'b0;
               rsp_data_in = {1'b0, INDEX_W'(0), color_ff, CHAR_BLANK,
                              ROW_W'(ROWS - 1), COLUMN_W'(0)};
               unit_op = CUR_BOTTOM;
               cursor_in = unit_cursor;
               phase_in = unit_phase;
               // resume a tab that ran across the bottom line end
               state_in = (count_ff != '0) ? ST_CELL : ST_CURSOR;
            end
         end
         ST_CURSOR: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_kind_in = KIND_CURSOR;
               rsp_last_in = 1'b1;
               rsp_data_in = {1'b0, index_full[INDEX_W-1:0], ATTR_W'(0), CHAR_W'(0),
                              cursor_ff.row, cursor_ff.column};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold the result until the transfer, then drop it
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_last_ff;

   // cursor stays on the screen; compare one bit wider so full-width sizes fit
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cursor_ff.column} < (COLUMN_W + 1)'(COLUMNS))
      && ({1'b0, cursor_ff.row} < (ROW_W + 1)'(ROWS)))
      else $error("cursor left the screen");

   // tab phase tracks the column and stays below the tab width
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff < PHASE_W'(TAB_WIDTH - 1)) || (phase_ff == PHASE_W'(TAB_WIDTH - 1)))
      else $error("tab phase out of range");

   // tlast marks exactly the cursor item
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_CURSOR)))
      else $error("tlast not on cursor item");

   // a taken character keeps the input closed on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input reopened before results");

   // a cell run never asks for more than the tab cap
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL) |-> (count_ff != '0) && (count_ff <= MAX_TAB_SPACES))
      else $error("cell count out of range");

endmodule
